@@ sv/ifr_pkg.sv @@
// Shared constants and types for the ISP frame receiver.
package ifr_pkg;

    localparam int unsigned HdrBytes      = 5;
    localparam int unsigned FrameOverhead = 6;

    localparam int unsigned PosW  = 17;
    localparam int unsigned SizeW = 16;

    typedef logic [PosW-1:0]  t_pos;
    typedef logic [SizeW-1:0] t_size;
    typedef logic [7:0]       t_byte;

    typedef enum logic {
        KIND_BODY = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    localparam t_pos POS_START = t_pos'(0);
    localparam t_pos POS_SEQ   = t_pos'(1);
    localparam t_pos POS_SIZEH = t_pos'(2);
    localparam t_pos POS_SIZEL = t_pos'(3);
    localparam t_pos POS_BODY  = t_pos'(HdrBytes);

endpackage

@@ sv/isp_frame_receiver_top.sv @@
// Top level of the ISP frame receiver: byte-stream deframer with XOR check.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_rx_byte
//  out     | from block| o_out_valid / i_out_ready | o_kind, o_data, o_body_index,
//          |           |                           | o_seq_num, o_frame_ok, o_last
//
//  One byte a cycle sustained while results are taken: a beat lands in the input
//  register, is decoded against the frame state and updates it once the decode stage
//  advances, and any result sits in the output register until taken.
//  Path from input beat to result beat: input register, then result register.
//  Synchronous active-low reset clears the frame state and both valid flags.
//  A stalled result holds the decode stage only when that stage has a result of
//  its own; header bytes drain through regardless.
module isp_frame_receiver_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ifr_pkg::t_byte      i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output ifr_pkg::t_byte      o_data,
    output logic [15:0]         o_body_index,
    output ifr_pkg::t_byte      o_seq_num,
    output logic                o_frame_ok,
    output logic                o_last
);
    import ifr_pkg::*;

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // Frame state
    t_pos  r_pos,  n_pos;
    t_size r_size, n_size;
    t_byte r_xor,  n_xor;
    t_byte r_seq,  n_seq;

    // Result register
    logic        r_out_valid;
    t_kind       r_kind,  n_kind;
    t_byte       r_data,  n_data;
    logic [15:0] r_index, n_index;
    t_byte       r_oseq,  n_oseq;
    logic        r_ok,    n_ok;

    logic  out_free;
    logic  has_result;
    logic  s1_move;
    logic  in_accept;
    t_pos  chk_pos;
    t_pos  body_off;

    assign out_free   = !r_out_valid || i_out_ready;
    // Position of the checksum byte: size plus the five header bytes.
    assign chk_pos    = t_pos'(r_size) + t_pos'(FrameOverhead - 1);
    assign has_result = (r_pos >= POS_BODY);
    // Advance the decode stage unless it holds a result that cannot be stored.
    assign s1_move    = r_in_valid && (!has_result || out_free);
    assign o_in_ready = !r_in_valid || s1_move;
    assign in_accept  = i_in_valid && o_in_ready;
    assign body_off   = r_pos - POS_BODY;

    // Decode one byte against the frame state.
    always_comb begin
        n_pos   = r_pos;
        n_size  = r_size;
        n_xor   = r_xor;
        n_seq   = r_seq;
        n_kind  = KIND_BODY;
        n_data  = '0;
        n_index = '0;
        n_oseq  = r_seq;
        n_ok    = 1'b0;
        priority if (r_pos < POS_BODY) begin
            // Header: restart the XOR on the start byte, capture fields.
            n_pos = r_pos + t_pos'(1);
            if (r_pos == POS_START) begin
                n_xor = r_in_byte;
            end else begin
                n_xor = r_xor ^ r_in_byte;
            end
            if (r_pos == POS_SEQ) begin
                n_seq = r_in_byte;
            end
            if (r_pos == POS_SIZEH) begin
                n_size = {r_in_byte, 8'h00};
            end
            if (r_pos == POS_SIZEL) begin
                n_size = {r_size[15:8], r_in_byte};
            end
        end else if (r_pos < chk_pos) begin
            // Body byte: pass it on with its index.
            n_pos   = r_pos + t_pos'(1);
            n_xor   = r_xor ^ r_in_byte;
            n_data  = r_in_byte;
            n_index = body_off[15:0];
        end else begin
            // Checksum byte: report and restart for the next frame.
            n_pos  = '0;
            n_xor  = '0;
            n_kind = KIND_END;
            n_ok   = (r_in_byte == r_xor);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_size      <= '0;
            r_xor       <= '0;
            r_seq       <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (s1_move) begin
                r_in_valid <= 1'b0;
            end
            if (s1_move) begin
                r_pos  <= n_pos;
                r_size <= n_size;
                r_xor  <= n_xor;
                r_seq  <= n_seq;
            end
            if (s1_move && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (s1_move && has_result) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_index <= n_index;
            r_oseq  <= n_oseq;
            r_ok    <= n_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data       = r_data;
    assign o_body_index = r_index;
    assign o_seq_num    = r_oseq;
    assign o_frame_ok   = r_ok;
    assign o_last       = (r_kind == KIND_END);

    // Position never runs past the checksum byte of the current frame.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_BODY) || (r_pos <= chk_pos))
        else $error("frame position beyond checksum byte");

    // An end result clears data and index.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_END) |-> (r_data == '0 && r_index == '0))
        else $error("end result carries body payload");

    // A body result never reports a good checksum.
    a_body_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_BODY) |-> !r_ok)
        else $error("body result flags frame_ok");

    // Checksum byte restarts the frame.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && has_result && !(r_pos < chk_pos)) |=> (r_pos == '0 && r_xor == '0))
        else $error("frame state not restarted after checksum");

    // Header bytes never stall the decode stage.
    a_hdr_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !has_result) |-> s1_move)
        else $error("header byte stalled");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ISP frame receiver: frame stimulus, prediction, result check.
`timescale 1ns / 100ps

module tb_top;
    import ifr_pkg::*;

    // One expected or observed result beat of the deframer
    typedef struct packed {
        t_kind       kind;
        t_byte       data;
        logic [15:0] body_index;
        t_byte       seq_num;
        logic        frame_ok;
        logic        last;
    } t_rx_result;

    typedef t_byte t_byte_q[$];

    // Every input is known from time zero; the tasks below take over at the rising edge
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_byte       i_rx_byte   = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    t_byte       o_data;
    logic [15:0] o_body_index;
    t_byte       o_seq_num;
    logic        o_frame_ok;
    logic        o_last;

    // Deframer state as the testbench predicts it
    t_pos  frame_pos;
    t_size body_len;
    t_byte run_xor;
    t_byte seq_cur;

    t_rx_result expected_results[$];

    // Idling controls; a long hold-off is requested through hold_req
    bit          send_idle_en;
    bit          recv_idle_en;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned stall_left;

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned frames_corrupt;
    int unsigned body_beats_seen;
    int unsigned end_beats_seen;
    int unsigned longest_body;

    isp_frame_receiver_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_body_index (o_body_index),
        .o_seq_num    (o_seq_num),
        .o_frame_ok   (o_frame_ok),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Advance the predicted frame state by one accepted byte and queue any result it causes
    task automatic deframe_byte(input t_byte b);
        t_rx_result r;
        t_pos       chk_pos;
        chk_pos = t_pos'(body_len) + t_pos'(FrameOverhead - 1);
        r = '0;
        if (frame_pos < POS_BODY) begin
            // header: no result, only the XOR and the captured fields move
            if (frame_pos == POS_START) begin
                run_xor = b;
            end else begin
                run_xor ^= b;
                case (frame_pos)
                    POS_SEQ:   seq_cur = b;
                    POS_SIZEH: body_len = {b, 8'h00};
                    POS_SIZEL: body_len[7:0] = b;
                    default:   ;
                endcase
            end
            frame_pos = frame_pos + 1'b1;
        end else if (frame_pos < chk_pos) begin
            run_xor ^= b;
            r.kind       = KIND_BODY;
            r.data       = b;
            r.body_index = 16'(frame_pos - POS_BODY);
            r.seq_num    = seq_cur;
            expected_results.push_back(r);
            frame_pos = frame_pos + 1'b1;
        end else begin
            // checksum byte: close the frame and restart the XOR
            r.kind     = KIND_END;
            r.seq_num  = seq_cur;
            r.frame_ok = (b == run_xor);
            r.last     = 1'b1;
            expected_results.push_back(r);
            frame_pos = POS_START;
            run_xor   = '0;
        end
    endtask

    // Offer one byte, hold it until the block takes it, then predict
    task automatic send_byte(input t_byte b);
        int unsigned gap;
        if (send_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Send a whole frame; the size header follows the body length, the checksum may be spoilt
    task automatic send_frame(input t_byte seq, input t_byte start_b, input t_byte token_b,
                              input bit corrupt, input t_byte_q body);
        t_size len;
        t_byte chk;
        len = t_size'(body.size());
        chk = start_b ^ seq ^ len[15:8] ^ len[7:0] ^ token_b;
        foreach (body[i]) chk ^= body[i];
        if (corrupt) chk ^= t_byte'($urandom_range(1, 255));
        send_byte(start_b);
        send_byte(seq);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(token_b);
        foreach (body[i]) send_byte(body[i]);
        send_byte(chk);
        frames_sent++;
        if (corrupt) frames_corrupt++;
        if (body.size() > longest_body) longest_body = body.size();
    endtask

    function automatic t_byte_q random_body(input int unsigned len);
        t_byte_q q;
        repeat (len) q.push_back(t_byte'($urandom_range(0, 255)));
        return q;
    endfunction

    // Well-formed frame with random content; roughly one in eight carries a bad checksum
    task automatic send_random_frame(input int unsigned len);
        send_frame(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                   t_byte'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                   random_body(len));
    endtask

    // Receiver: a requested hold-off first, then random stall bursts
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_req - 1;
            hold_req     = 0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Check every result beat against the oldest expectation
    t_rx_result exp_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual kind %0d seq %0d",
                         $time, o_kind, o_seq_num);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_kind !== exp_res.kind)             report("kind", exp_res.kind, o_kind);
                if (o_data !== exp_res.data)             report("data", exp_res.data, o_data);
                if (o_body_index !== exp_res.body_index)
                    report("body_index", exp_res.body_index, o_body_index);
                if (o_seq_num !== exp_res.seq_num)
                    report("seq_num", exp_res.seq_num, o_seq_num);
                if (o_frame_ok !== exp_res.frame_ok)
                    report("frame_ok", exp_res.frame_ok, o_frame_ok);
                if (o_last !== exp_res.last)             report("last", exp_res.last, o_last);
                if (exp_res.kind == KIND_END) end_beats_seen++;
                else body_beats_seen++;
            end
        end
    end

    // Extremes of the start, sequence and token bytes, empty bodies, body bytes at both ends, bad checksums
    task automatic test_directed();
        t_byte_q body;
        send_frame(8'h00, 8'h00, 8'h00, 1'b0, body);
        send_frame(8'hFF, 8'hFF, 8'hFF, 1'b1, body);
        body = '{8'h00, 8'hFF, 8'hA5};
        send_frame(8'h5A, 8'h1B, 8'h0E, 1'b0, body);
        body = '{8'hFF, 8'h00};
        send_frame(8'h01, 8'hFF, 8'h00, 1'b1, body);
    endtask

    // Mostly short frames with idling switched per frame, plus one body past 255 bytes
    task automatic test_random_frames();
        int unsigned start_count;
        start_count = bytes_sent;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        send_random_frame($urandom_range(256, 320));
        while (bytes_sent - start_count < 300) begin
            send_idle_en = $urandom_range(0, 3) != 0;
            recv_idle_en = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0) send_random_frame($urandom_range(0, 3));
            else send_random_frame($urandom_range(0, 24));
        end
    endtask

    // Hold the receiver off while body bytes keep coming, so the block fills and stalls its input
    task automatic test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b1;
        hold_req = 300;
        send_random_frame(80);
    endtask

    // Long body with both size bytes in use and the low size byte all ones
    task automatic test_long_body();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        send_random_frame(511);
    endtask

    // Final stretch at full rate on both sides
    task automatic test_full_rate();
        int unsigned start_count;
        start_count = bytes_sent;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        while (bytes_sent - start_count < 200) send_random_frame($urandom_range(0, 20));
    endtask

    // Drop valid, drain the expectations, allow for the pipeline, then give the verdict
    task automatic finish_run();
        int unsigned waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: results outstanding: expected 0, actual %0d",
                     $time, expected_results.size());
            errors += expected_results.size();
        end
        $display("Sent %0d bytes in %0d frames (%0d with a bad checksum), longest body %0d.",
                 bytes_sent, frames_sent, frames_corrupt, longest_body);
        $display("Checked %0d body beats and %0d end-of-frame beats, %0d mismatches.",
                 body_beats_seen, end_beats_seen, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    endtask

    initial begin
        frame_pos = POS_START;
        body_len  = '0;
        run_xor   = '0;
        seq_cur   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames();
        test_backpressure();
        test_long_body();
        test_full_rate();
        finish_run();
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ifr_pkg.sv
sv/isp_frame_receiver_top.sv
sim/tb_top.sv
